### rtl/core/fpf_pkg.sv
// Package: item types, parse phases, tag and status codes for the property finder.
`default_nettype none

package fpf_pkg;

  typedef enum logic [2:0] {
    PH_TAG   = 3'd0,
    PH_NAME  = 3'd1,
    PH_PAD   = 3'd2,
    PH_PLEN  = 3'd3,
    PH_POFF  = 3'd4,
    PH_VALUE = 3'd5,
    PH_SKIP  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  localparam logic [31:0] TAG_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TAG_PROP       = 32'h0000_0003;

  localparam logic [1:0] STATUS_VALUE     = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [7:0] struct_byte;
    logic       block_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/fpf_parser.sv
// Parse state of the structure block and the result of each accepted byte.
`default_nettype none

module fpf_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire fpf_pkg::in_item_t item,
  input  wire logic [31:0]       wanted_offset,
  output logic                   emit,
  output fpf_pkg::out_item_t     res
);
  import fpf_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] acc, acc_next;
  logic [1:0]  biw, biw_next;
  logic [1:0]  pos, pos_next;
  logic [31:0] plen, plen_next;
  logic [31:0] brem, brem_next;
  logic        match_done, match_done_next;

  logic [31:0] word_full;
  logic [1:0]  biw_inc;
  logic [31:0] brem_dec;
  logic        word_phase;
  logic        hit;

  assign word_full  = {acc[23:0], item.struct_byte};
  assign biw_inc    = biw + 2'd1;
  assign brem_dec   = brem - 32'd1;
  assign pos_next   = pos + 2'd1;
  assign word_phase = (phase == PH_TAG) || (phase == PH_PLEN) || (phase == PH_POFF);
  assign hit        = (phase == PH_POFF) && (biw_inc == 2'd0) && (word_full == wanted_offset);

  // next state
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    biw_next        = biw;
    plen_next       = plen;
    brem_next       = brem;
    match_done_next = match_done;
    if (word_phase) begin
      acc_next = word_full;
      biw_next = biw_inc;
    end
    unique case (phase)
      PH_TAG, PH_PLEN, PH_POFF: begin
        if (biw_inc == 2'd0) begin
          priority if (phase == PH_TAG) begin
            if (word_full == TAG_BEGIN_NODE) phase_next = PH_NAME;
            else if (word_full == TAG_PROP) phase_next = PH_PLEN;
          end else if (phase == PH_PLEN) begin
            plen_next  = word_full;
            phase_next = PH_POFF;
          end else if (hit) begin
            match_done_next = 1'b1;
            if (plen == 32'd0) begin
              phase_next = PH_DONE;
            end else begin
              brem_next  = plen;
              phase_next = PH_VALUE;
            end
          end else if (plen == 32'd0) begin
            phase_next = PH_TAG;
          end else begin
            brem_next  = plen;
            phase_next = PH_SKIP;
          end
        end
      end
      PH_NAME: begin
        if (item.struct_byte == 8'd0) phase_next = (pos_next == 2'd0) ? PH_TAG : PH_PAD;
      end
      PH_PAD: begin
        if (pos_next == 2'd0) phase_next = PH_TAG;
      end
      PH_SKIP: begin
        brem_next = brem_dec;
        if (brem_dec == 32'd0) phase_next = (pos_next == 2'd0) ? PH_TAG : PH_PAD;
      end
      PH_VALUE: begin
        brem_next = brem_dec;
        if (brem_dec == 32'd0) phase_next = PH_DONE;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // result of this byte, then the block-end overlay
  always_comb begin
    emit = 1'b0;
    res  = '{value_byte: 8'd0, status: STATUS_VALUE, last: 1'b0};
    if (phase == PH_VALUE) begin
      emit           = 1'b1;
      res.value_byte = item.struct_byte;
      res.last       = (brem == 32'd1);
    end else if (hit && (plen == 32'd0)) begin
      emit       = 1'b1;
      res.status = STATUS_EMPTY;
      res.last   = 1'b1;
    end
    if (item.block_end) begin
      priority if (emit) begin
        res.last = 1'b1;
      end else if (phase_next == PH_VALUE) begin
        emit       = 1'b1;
        res.status = STATUS_EMPTY;
        res.last   = 1'b1;
      end else if (!match_done_next) begin
        emit       = 1'b1;
        res.status = STATUS_NOT_FOUND;
        res.last   = 1'b1;
      end else begin
        // match already reported: drop the closing byte
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.block_end)) begin
      phase      <= PH_TAG;
      acc        <= '0;
      biw        <= '0;
      pos        <= '0;
      plen       <= '0;
      brem       <= '0;
      match_done <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      acc        <= acc_next;
      biw        <= biw_next;
      pos        <= pos_next;
      plen       <= plen_next;
      brem       <= brem_next;
      match_done <= match_done_next;
    end
  end

  a_value_needs_match: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VALUE) |-> (match_done && (brem != 32'd0)))
    else $error("value phase without a live match");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.block_end) |=> ((phase == PH_TAG) && !match_done && (biw == 2'd0)))
    else $error("block end did not clear the parse");

  a_non_value_zero: assert property (@(posedge clk) disable iff (rst)
    (emit && (res.status != STATUS_VALUE)) |-> ((res.value_byte == 8'd0) && res.last))
    else $error("status result carries a byte or lacks last");

endmodule

`default_nettype wire

### rtl/core/fpf_out_reg.sv
// Result register between the parser and the result channel.
`default_nettype none

module fpf_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire fpf_pkg::out_item_t load_item,
  output logic                    can_load,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output fpf_pkg::out_item_t      result
);
  import fpf_pkg::*;

  assign can_load = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= load;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (can_load && load) begin
      result <= load_item;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !can_load)
    else $error("held item could be overwritten");

endmodule

`default_nettype wire

### rtl/core/fdt_property_finder_core.sv
// Top level of the flattened device tree property finder.
// Feed the structure block one byte per item, with block_end on its final byte;
// cfg_wdata, written while idle, gives the wanted name offset in the strings block.
// One byte is accepted per unstalled cycle; each byte is handled in the cycle it is
// accepted and its result, if any, appears in the result register on the next
// cycle. The byte channel stalls only while that register holds an item that the
// result channel is stalling. Results are value bytes of the matching property
// (last on its final byte), one empty-found item, or one not-found item at block end.
`default_nettype none

module fdt_property_finder_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              byte_valid,
  output logic                   byte_stall,
  input  wire fpf_pkg::in_item_t byte_item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output fpf_pkg::out_item_t     result
);
  import fpf_pkg::*;

  logic [31:0] wanted_offset;
  logic        accept;
  logic        can_load;
  logic        emit;
  out_item_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_offset <= '0;
    end else if (cfg_we) begin
      wanted_offset <= cfg_wdata;
    end
  end

  assign byte_stall = !can_load;
  assign accept     = byte_valid && can_load;

  fpf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (byte_item),
    .wanted_offset (wanted_offset),
    .emit          (emit),
    .res           (res)
  );

  fpf_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && emit),
    .load_item    (res),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for fdt_property_finder_core: byte streams of device tree blocks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpf_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_BYTES = 140;
  localparam int HOLD_CYCLES = 150;

  localparam logic [31:0] TAG_END_NODE = 32'h0000_0002;
  localparam logic [31:0] TAG_NOP      = 32'h0000_0004;
  localparam logic [31:0] TAG_END      = 32'h0000_0009;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  in_item_t    byte_item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;

  fdt_property_finder_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Lookup state mirrored from the block
  phase_t      parse_ph;
  logic [31:0] word_acc;
  logic [1:0]  word_pos;
  logic [1:0]  block_pos;
  logic [31:0] prop_len;
  logic [31:0] value_left;
  logic        found;
  logic [31:0] wanted_offset;

  out_item_t   expected_results[$];
  logic [7:0]  block_bytes[$];
  dir_row_t    directed[$];
  logic [31:0] phase_offset[PHASE_COUNT];

  int   error_count = 0;
  int   cycle_count = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  logic calm = 1'b0;

  task automatic finder_restart();
    parse_ph   = PH_TAG;
    word_acc   = '0;
    word_pos   = '0;
    block_pos  = '0;
    prop_len   = '0;
    value_left = '0;
    found      = 1'b0;
  endtask

  task automatic finder_step(input in_item_t it);
    logic       emit;
    out_item_t  res;
    logic [1:0] next_pos;
    emit = 1'b0;
    res = '0;
    next_pos = block_pos + 2'd1;
    case (parse_ph)
      PH_TAG, PH_PLEN, PH_POFF: begin
        word_acc = {word_acc[23:0], it.struct_byte};
        word_pos = word_pos + 2'd1;
        if (word_pos == 2'd0) begin
          if (parse_ph == PH_TAG) begin
            if (word_acc == TAG_BEGIN_NODE) parse_ph = PH_NAME;
            else if (word_acc == TAG_PROP) parse_ph = PH_PLEN;
          end else if (parse_ph == PH_PLEN) begin
            prop_len = word_acc;
            parse_ph = PH_POFF;
          end else if (word_acc == wanted_offset) begin
            found = 1'b1;
            if (prop_len == 32'd0) begin
              emit = 1'b1;
              res.status = STATUS_EMPTY;
              res.last = 1'b1;
              parse_ph = PH_DONE;
            end else begin
              value_left = prop_len;
              parse_ph = PH_VALUE;
            end
          end else if (prop_len == 32'd0) begin
            parse_ph = PH_TAG;
          end else begin
            value_left = prop_len;
            parse_ph = PH_SKIP;
          end
        end
      end
      PH_NAME: begin
        if (it.struct_byte == 8'h00) parse_ph = (next_pos == 2'd0) ? PH_TAG : PH_PAD;
      end
      PH_PAD: begin
        if (next_pos == 2'd0) parse_ph = PH_TAG;
      end
      PH_SKIP: begin
        value_left = value_left - 32'd1;
        if (value_left == 32'd0) parse_ph = (next_pos == 2'd0) ? PH_TAG : PH_PAD;
      end
      PH_VALUE: begin
        emit = 1'b1;
        res.value_byte = it.struct_byte;
        res.status = STATUS_VALUE;
        res.last = (value_left == 32'd1);
        value_left = value_left - 32'd1;
        if (value_left == 32'd0) parse_ph = PH_DONE;
      end
      default: ;
    endcase
    block_pos = next_pos;

    if (it.block_end) begin
      if (emit) begin
        res.last = 1'b1;
      end else if (parse_ph == PH_VALUE) begin
        // match found but the block holds none of its bytes
        emit = 1'b1;
        res.status = STATUS_EMPTY;
        res.last = 1'b1;
      end else if (!found) begin
        emit = 1'b1;
        res.status = STATUS_NOT_FOUND;
        res.last = 1'b1;
      end
      finder_restart();
    end
    if (emit) expected_results.push_back(res);
  endtask

  function automatic dir_row_t dir_row(input logic [7:0] b, input logic closes,
                                       input logic typed = 1'b0,
                                       input logic [1:0] status = STATUS_VALUE);
    dir_row_t r;
    r.item.struct_byte = b;
    r.item.block_end = closes;
    r.typed = typed;
    r.want.value_byte = 8'h00;
    r.want.status = status;
    r.want.last = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] pick_name_offset();
    case ($urandom_range(0, 9))
      0, 1, 2: return wanted_offset;
      3, 4:    return wanted_offset ^ (32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic put_word(input logic [31:0] w);
    block_bytes.push_back(w[31:24]);
    block_bytes.push_back(w[23:16]);
    block_bytes.push_back(w[15:8]);
    block_bytes.push_back(w[7:0]);
  endtask

  task automatic pad_block();
    while (block_bytes.size() % 4 != 0) block_bytes.push_back(8'($urandom));
  endtask

  task automatic build_block();
    int          pick;
    int          n;
    int          cut;
    logic [31:0] w;
    block_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // plain noise
      repeat ($urandom_range(1, 12)) block_bytes.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          put_word(TAG_BEGIN_NODE);
          repeat ($urandom_range(0, 10)) block_bytes.push_back(8'($urandom_range(1, 255)));
          block_bytes.push_back(8'h00);
          pad_block();
        end
        2: put_word(TAG_END_NODE);
        3: put_word(TAG_NOP);
        4: put_word(TAG_END);
        5: begin
          w = $urandom;
          if (w == TAG_BEGIN_NODE || w == TAG_PROP) w = TAG_NOP;
          put_word(w);
        end
        default: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          put_word(TAG_PROP);
          put_word(n);
          put_word(pick_name_offset());
          repeat (n) block_bytes.push_back(8'($urandom));
          pad_block();
        end
      endcase
    end
    if (pick < 14) begin
      // runaway length: the block closes before the value ends
      put_word(TAG_PROP);
      put_word(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : (32'h8000_0000 | $urandom));
      put_word(pick_name_offset());
      repeat ($urandom_range(0, 6)) block_bytes.push_back(8'($urandom));
    end else if (pick < 32) begin
      cut = $urandom_range(1, block_bytes.size());
      while (block_bytes.size() > cut) void'(block_bytes.pop_back());
    end
  endtask

  // Called just after a falling edge; returns just after a falling edge, once the byte has been accepted.
  task automatic offer_byte(input in_item_t it, input logic typed, input out_item_t want);
    int queued;
    if (!calm && $urandom_range(0, 99) < 8) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (byte_stall);
    queued = expected_results.size();
    finder_step(it);
    if (typed) begin
      while (expected_results.size() > queued) void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
    @(negedge clk);
  endtask

  // Result side: random stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = holds_served + 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: value_byte %0h status %0d last %0b",
               result.value_byte, result.status, result.last);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.value_byte !== want.value_byte) begin
          $error("value_byte: expected %0h, got %0h", want.value_byte, result.value_byte);
          error_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          error_count++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fdt_property_finder_core: mismatch");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int       sent;
    finder_restart();
    wanted_offset = '0;
    phase_offset = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom_range(0, 255),
                     32'h8000_0000, $urandom, TAG_PROP, TAG_BEGIN_NODE};

    directed = '{
      // block closed mid-word, nothing found
      dir_row(8'hFF, 1'b1, 1'b1, STATUS_NOT_FOUND),
      // zero-length property at the reset offset
      dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h03, 1'b0),
      dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0),
      dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0),
      dir_row(8'h00, 1'b0, 1'b1, STATUS_EMPTY),
      // close after a completed match: no item
      dir_row(8'hFF, 1'b1),
      // match of length 5, block closes on the offset word
      dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h03, 1'b0),
      dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h05, 1'b0),
      dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0), dir_row(8'h00, 1'b0),
      dir_row(8'h00, 1'b1, 1'b1, STATUS_EMPTY)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer_byte(directed[i].item, directed[i].typed, directed[i].want);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      // drain before touching the offset register
      byte_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_offset[ph];
      @(posedge clk);
      wanted_offset = phase_offset[ph];
      calm = (ph == 2);
      if (ph == 4) hold_requests++;
      @(negedge clk);
      cfg_we <= 1'b0;

      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_block();
        foreach (block_bytes[i]) begin
          it.struct_byte = block_bytes[i];
          it.block_end = (i == block_bytes.size() - 1);
          offer_byte(it, 1'b0, '0);
        end
        sent += block_bytes.size();
      end
    end

    byte_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("fdt_property_finder_core: match");
    end else begin
      $display("fdt_property_finder_core: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/fpf_pkg.sv
rtl/core/fpf_parser.sv
rtl/core/fpf_out_reg.sv
rtl/core/fdt_property_finder_core.sv
test/tb_top.sv
